// ===== hdl/three_channel_feedback_delay_top_macros.svh =====
// Assertion macros shared by the feedback delay modules.
`ifndef THREE_CHANNEL_FEEDBACK_DELAY_TOP_MACROS_SVH
`define THREE_CHANNEL_FEEDBACK_DELAY_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCFD_ASSERT_NOW(label, ante, cons, msg)
`define TCFD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/tcfd_pkg.sv =====
// Package with constants, register indexes and shared types of the feedback delay.
package tcfd_pkg;

  localparam int MaxBlocksDef    = 128;
  localparam int BlockSamplesDef = 160;
  localparam int SampleW         = 32;
  localparam int GainW           = 8;
  localparam int CfgDataW        = 16;
  localparam int CfgIndexW       = 3;
  localparam logic [GainW-1:0] GainMax = 8'd128;

  typedef enum logic [CfgIndexW-1:0] {
    REG_LEFT_BLOCKS     = 3'd0,
    REG_RIGHT_BLOCKS    = 3'd1,
    REG_SURROUND_BLOCKS = 3'd2,
    REG_LEFT_GAINS      = 3'd3,
    REG_RIGHT_GAINS     = 3'd4,
    REG_SURROUND_GAINS  = 3'd5
  } tcfd_reg_e;

  typedef struct packed {
    logic accept;
    logic advance;
    logic clear;
  } tcfd_ctl_t;

  function automatic logic [GainW-1:0] clamp_gain(input logic [GainW-1:0] g);
    return (g > GainMax) ? GainMax : g;
  endfunction

endpackage

// ===== hdl/three_channel_feedback_delay_top.sv =====
// Top level of the three channel feedback delay: handshake, configuration decode, channels.
//
// Sustained rate is one item per clock cycle while the output is taken; a new item can
// enter while the last is in flight. An item passes the read stage (the line memory is
// read at the accepting edge), then the output register: as it advances it is scaled,
// written back and its echo registered. Each channel keeps its line in one memory
// that is read at the write pointer and written back as the item advances, with
// forwarding when both touch the same entry. Reset and size writes take effect at once:
// no clearing pass runs, as entries not yet reached since the last rewind read as zero.
`include "three_channel_feedback_delay_top_macros.svh"
module three_channel_feedback_delay_top import tcfd_pkg::*; #(
  parameter int MaxBlocks    = MaxBlocksDef,
  parameter int BlockSamples = BlockSamplesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SampleW-1:0]  left_sample_i,
  input  logic signed [SampleW-1:0]  right_sample_i,
  input  logic signed [SampleW-1:0]  surround_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SampleW-1:0]  left_echo_o,
  output logic signed [SampleW-1:0]  right_echo_o,
  output logic signed [SampleW-1:0]  surround_echo_o,
  input  logic                       cfg_we_i,
  input  logic [CfgIndexW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  logic      s1_valid_q, s1_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      advance, accept;
  tcfd_ctl_t ctl;
  logic [2:0] size_we, gain_we;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    size_we = '0;
    gain_we = '0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LEFT_BLOCKS:     size_we[0] = 1'b1;
        REG_RIGHT_BLOCKS:    size_we[1] = 1'b1;
        REG_SURROUND_BLOCKS: size_we[2] = 1'b1;
        REG_LEFT_GAINS:      gain_we[0] = 1'b1;
        REG_RIGHT_GAINS:     gain_we[1] = 1'b1;
        REG_SURROUND_GAINS:  gain_we[2] = 1'b1;
        default: begin
          size_we = '0;
          gain_we = '0;
        end
      endcase
    end
  end

  always_comb begin
    ctl.accept  = accept;
    ctl.advance = advance;
    ctl.clear   = |size_we;
  end

  tcfd_channel #(
    .MaxBlocks    (MaxBlocks),
    .BlockSamples (BlockSamples)
  ) u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .size_we_i  (size_we[0]),
    .gain_we_i  (gain_we[0]),
    .cfg_data_i (cfg_data_i),
    .sample_i   (left_sample_i),
    .echo_o     (left_echo_o)
  );

  tcfd_channel #(
    .MaxBlocks    (MaxBlocks),
    .BlockSamples (BlockSamples)
  ) u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .size_we_i  (size_we[1]),
    .gain_we_i  (gain_we[1]),
    .cfg_data_i (cfg_data_i),
    .sample_i   (right_sample_i),
    .echo_o     (right_echo_o)
  );

  tcfd_channel #(
    .MaxBlocks    (MaxBlocks),
    .BlockSamples (BlockSamples)
  ) u_surround (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .size_we_i  (size_we[2]),
    .gain_we_i  (gain_we[2]),
    .cfg_data_i (cfg_data_i),
    .sample_i   (surround_sample_i),
    .echo_o     (surround_echo_o)
  );

  assign out_valid_o = out_valid_q;

  `TCFD_ASSERT_NOW(a_full_blocks_input, s1_valid_q && out_valid_q && !out_ready_i,
                   !in_ready_o, "item taken while both stages are held")
  `TCFD_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_q,
                    "advanced item did not reach the output register")
  `TCFD_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_q,
                    "accepted item did not enter the read stage")

endmodule

// ===== hdl/tcfd_channel.sv =====
// One channel: delay ring memory, write pointer, gains and read-modify-write datapath.
`include "three_channel_feedback_delay_top_macros.svh"
module tcfd_channel import tcfd_pkg::*; #(
  parameter int MaxBlocks    = MaxBlocksDef,
  parameter int BlockSamples = BlockSamplesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcfd_ctl_t                  ctl_i,
  input  logic                       size_we_i,
  input  logic                       gain_we_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic signed [SampleW-1:0]  sample_i,
  output logic signed [SampleW-1:0]  echo_o
);

  localparam int LineDepth = MaxBlocks * BlockSamples;
  localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  logic [SampleW-1:0] mem [LineDepth];
  logic [SampleW-1:0] rdata_q;

  logic [AddrW-1:0]   pos_q, pos_d;
  logic               wrapped_q, wrapped_d;
  logic [AddrW-1:0]   last_q, last_d;
  logic [GainW-1:0]   fb_q, og_q;

  logic [AddrW-1:0]   s1_addr_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_wr_q;
  logic               s1_hit_q;
  logic [SampleW-1:0] s1_fwd_q;
  logic [SampleW-1:0] echo_q;

  logic [31:0]              blk;
  logic [31:0]              blk_clamped;
  logic [SampleW-1:0]       old;
  logic signed [SampleW+GainW:0] fb_prod, og_prod;
  logic [SampleW-1:0]       fb_lo, og_lo;
  logic [SampleW-1:0]       wr_data, echo_d;

  always_comb begin
    blk = {24'd0, cfg_data_i[7:0]};
    if (blk == 32'd0) begin
      blk_clamped = 32'd1;
    end else if (blk > 32'(MaxBlocks)) begin
      blk_clamped = 32'(MaxBlocks);
    end else begin
      blk_clamped = blk;
    end
    last_d = AddrW'(blk_clamped * 32'(BlockSamples) - 32'd1);
  end

  always_comb begin
    pos_d     = pos_q;
    wrapped_d = wrapped_q;
    if (ctl_i.clear) begin
      pos_d     = '0;
      wrapped_d = 1'b0;
    end else if (ctl_i.accept) begin
      if (pos_q == last_q) begin
        pos_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        pos_d = pos_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      last_q    <= AddrW'(BlockSamples - 1);
      fb_q      <= '0;
      og_q      <= '0;
    end else begin
      pos_q     <= pos_d;
      wrapped_q <= wrapped_d;
      if (size_we_i) begin
        last_q <= last_d;
      end
      if (gain_we_i) begin
        fb_q <= clamp_gain(cfg_data_i[7:0]);
        og_q <= clamp_gain(cfg_data_i[15:8]);
      end
    end
  end

  // entries past the pointer before the first wrap were never written: read zero
  always_comb begin
    if (s1_hit_q) begin
      old = s1_fwd_q;
    end else if (s1_wr_q) begin
      old = rdata_q;
    end else begin
      old = '0;
    end
    fb_prod = $signed({{(GainW+1){old[SampleW-1]}}, old}) *
              $signed({{(SampleW+1){1'b0}}, fb_q});
    og_prod = $signed({{(GainW+1){old[SampleW-1]}}, old}) *
              $signed({{(SampleW+1){1'b0}}, og_q});
    fb_lo   = fb_prod[SampleW-1:0];
    og_lo   = og_prod[SampleW-1:0];
    wr_data = s1_sample_q + {{7{fb_lo[SampleW-1]}}, fb_lo[SampleW-1:7]};
    echo_d  = {{7{og_lo[SampleW-1]}}, og_lo[SampleW-1:7]};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      mem[s1_addr_q] <= wr_data;
    end
    if (ctl_i.accept) begin
      rdata_q <= mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      s1_addr_q   <= pos_q;
      s1_sample_q <= sample_i;
      s1_wr_q     <= wrapped_q;
      s1_hit_q    <= ctl_i.advance && (s1_addr_q == pos_q);
      s1_fwd_q    <= wr_data;
    end
    if (ctl_i.advance) begin
      echo_q <= echo_d;
    end
  end

  assign echo_o = echo_q;

  `TCFD_ASSERT_NOW(a_pos_in_line, 1'b1, pos_q <= last_q, "write pointer beyond line end")
  `TCFD_ASSERT_NEXT(a_clear_rewinds, ctl_i.clear, (pos_q == '0) && !wrapped_q,
                    "size write did not rewind the line")
  `TCFD_ASSERT_NEXT(a_wrap_marks, ctl_i.accept && !ctl_i.clear && (pos_q == last_q),
                    wrapped_q && (pos_q == '0), "wrap did not mark the line as filled")

endmodule
